/* rtl/nrpe_pkg.sv */
package nrpe_pkg;

  // Field limits of the parser.
  localparam int FRAC_DIGITS = 5;
  localparam int MAX_FIELD   = 30;
  localparam int HEADER_LEN  = 5;
  localparam int SHORT_FIELD = 5;

  localparam int INT_W  = 17;
  localparam int FRAC_W = 17;
  localparam int FCNT_W = 3;
  localparam int FLEN_W = 5;
  localparam int HC_W   = 3;

  localparam logic [INT_W-1:0] INT_SAT = 17'd131071;

  // Characters of interest.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;

  // Conversion constants.
  localparam logic [30:0] LAT_LIMIT = 31'd900000000;
  localparam logic [30:0] LON_LIMIT = 31'd1800000000;
  localparam logic [23:0] E7        = 24'd10000000;
  // floor(2^22 / 100): quotient is exact or one low for 17-bit inputs.
  localparam logic [15:0] DIV100_K  = 16'd41943;
  // floor(2^32 / 15): quotient is exact or one low for 28-bit inputs.
  localparam logic [28:0] DIV15_K   = 29'd286331153;

  // Queue depths.
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int RQ_DEPTH = 2;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  // One coordinate field handed from the parser to the converter.
  typedef struct packed {
    logic [INT_W-1:0]  int_acc;
    logic [FRAC_W-1:0] frac_acc;
    logic [FCNT_W-1:0] frac_cnt;
    logic              zero;
    logic              neg;
    logic              is_lon;
    logic              status;
  } job_t;

  // Control tag that rides along the conversion pipeline.
  typedef struct packed {
    logic zero;
    logic neg;
    logic is_lon;
    logic status;
  } tag_t;

  typedef struct packed {
    logic signed [30:0] latitude_e7;
    logic signed [31:0] longitude_e7;
    logic               status_active;
  } res_t;

  function automatic logic [7:0] header_char(input logic [HC_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h47; // G
      3'd1:    ch = 8'h50; // P
      3'd2:    ch = 8'h52; // R
      3'd3:    ch = 8'h4D; // M
      3'd4:    ch = 8'h43; // C
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // 10^n for the kept fraction digits.
  function automatic logic [16:0] pow10(input logic [FCNT_W-1:0] n);
    logic [16:0] v;
    case (n)
      3'd0:    v = 17'd1;
      3'd1:    v = 17'd10;
      3'd2:    v = 17'd100;
      3'd3:    v = 17'd1000;
      3'd4:    v = 17'd10000;
      3'd5:    v = 17'd100000;
      default: v = 17'd1;
    endcase
    return v;
  endfunction

  // 10^(7-n): scales minutes * 10^n up to minutes * 10^7.
  function automatic logic [23:0] scale7(input logic [FCNT_W-1:0] n);
    logic [23:0] v;
    case (n)
      3'd0:    v = 24'd10000000;
      3'd1:    v = 24'd1000000;
      3'd2:    v = 24'd100000;
      3'd3:    v = 24'd10000;
      3'd4:    v = 24'd1000;
      3'd5:    v = 24'd100;
      3'd6:    v = 24'd10;
      default: v = 24'd1;
    endcase
    return v;
  endfunction

endpackage

/* rtl/nrpe_front.sv */
module nrpe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  output logic                job_push,
  output nrpe_pkg::job_t      job
);
  import nrpe_pkg::*;

  localparam logic [2:0] PH_WAIT     = 3'd0;
  localparam logic [2:0] PH_HEADER   = 3'd1;
  localparam logic [2:0] PH_STATUS   = 3'd2;
  localparam logic [2:0] PH_LAT_NUM  = 3'd3;
  localparam logic [2:0] PH_LAT_HEMI = 3'd4;
  localparam logic [2:0] PH_LON_NUM  = 3'd5;
  localparam logic [2:0] PH_LON_HEMI = 3'd6;

  logic [2:0]        phase_r, phase_nxt;
  logic [HC_W-1:0]   hc_r, hc_nxt;
  logic              hok_r, hok_nxt;
  logic [INT_W-1:0]  int_r, int_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic              dot_r, dot_nxt;
  logic [FLEN_W-1:0] flen_r, flen_nxt;
  logic              status_r, status_nxt;

  logic              is_digit, is_ns, is_ew, hok_upd, clear, field_char;
  logic [3:0]        digit;
  logic [20:0]       int_x10;
  logic [HC_W:0]     hc_inc;

  assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
  assign digit    = 4'(rx_byte - CH_0);
  assign is_ns    = (rx_byte == CH_N) || (rx_byte == CH_S);
  assign is_ew    = (rx_byte == CH_E) || (rx_byte == CH_W);
  assign int_x10  = 21'(int_r) * 21'd10 + 21'(digit);
  assign hc_inc   = {1'b0, hc_r} + 4'd1;
  assign hok_upd  = hok_r & ~((hc_r < HC_W'(HEADER_LEN)) && (rx_byte != header_char(hc_r)));

  always_comb begin
    phase_nxt  = phase_r;
    hc_nxt     = hc_r;
    hok_nxt    = hok_r;
    int_nxt    = int_r;
    frac_nxt   = frac_r;
    fcnt_nxt   = fcnt_r;
    dot_nxt    = dot_r;
    flen_nxt   = flen_r;
    status_nxt = status_r;
    clear      = 1'b0;
    field_char = 1'b0;
    job_push   = 1'b0;

    job.int_acc  = int_r;
    job.frac_acc = frac_r;
    job.frac_cnt = fcnt_r;
    job.zero     = (flen_r <= FLEN_W'(SHORT_FIELD));
    job.neg      = (rx_byte == CH_S) || (rx_byte == CH_W);
    job.is_lon   = (phase_r == PH_LON_NUM) || (phase_r == PH_LON_HEMI);
    job.status   = status_r;

    if (take && (rx_byte != CH_NUL)) begin
      if (rx_byte == CH_DOLLAR) begin
        phase_nxt = PH_HEADER;
        hc_nxt    = '0;
        hok_nxt   = 1'b1;
        clear     = 1'b1;
      end else begin
        case (phase_r)
          PH_WAIT: begin
          end
          PH_HEADER: begin
            hok_nxt = hok_upd;
            hc_nxt  = hc_inc[HC_W-1:0];
            if (hc_inc >= (HC_W+1)'(HEADER_LEN)) begin
              phase_nxt = hok_upd ? PH_STATUS : PH_WAIT;
              hc_nxt    = '0;
            end
          end
          PH_STATUS: begin
            if ((rx_byte == CH_A) || (rx_byte == CH_V)) begin
              status_nxt = (rx_byte == CH_A);
              clear      = 1'b1;
              phase_nxt  = PH_LAT_NUM;
            end
          end
          PH_LAT_NUM: begin
            if (is_ns) begin
              job_push  = 1'b1;
              clear     = 1'b1;
              phase_nxt = PH_LON_NUM;
            end else if (rx_byte == CH_COMMA) begin
              if (flen_r != '0) phase_nxt = PH_LAT_HEMI;
            end else begin
              field_char = 1'b1;
            end
          end
          PH_LAT_HEMI: begin
            if (is_ns) begin
              job_push  = 1'b1;
              clear     = 1'b1;
              phase_nxt = PH_LON_NUM;
            end
          end
          PH_LON_NUM: begin
            if (is_ew) begin
              job_push  = 1'b1;
              clear     = 1'b1;
              phase_nxt = PH_WAIT;
            end else if (rx_byte == CH_COMMA) begin
              if (flen_r != '0) phase_nxt = PH_LON_HEMI;
            end else begin
              field_char = 1'b1;
            end
          end
          PH_LON_HEMI: begin
            if (is_ew) begin
              job_push  = 1'b1;
              clear     = 1'b1;
              phase_nxt = PH_WAIT;
            end
          end
          default: begin
            phase_nxt = PH_WAIT;
          end
        endcase
      end
    end

    // A character inside a number field; an overlong field drops the sentence.
    if (field_char) begin
      if (flen_r >= FLEN_W'(MAX_FIELD)) begin
        clear     = 1'b1;
        phase_nxt = PH_WAIT;
      end else begin
        flen_nxt = flen_r + 1'b1;
        if (is_digit) begin
          if (!dot_r) begin
            int_nxt = (int_x10 > 21'(INT_SAT)) ? INT_SAT : int_x10[INT_W-1:0];
          end else if (fcnt_r < FCNT_W'(FRAC_DIGITS)) begin
            frac_nxt = 17'(frac_r * 17'd10 + 17'(digit));
            fcnt_nxt = fcnt_r + 1'b1;
          end
        end else if (rx_byte == CH_DOT) begin
          dot_nxt = 1'b1;
        end
      end
    end

    if (clear) begin
      int_nxt  = '0;
      frac_nxt = '0;
      fcnt_nxt = '0;
      dot_nxt  = 1'b0;
      flen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      hc_r     <= '0;
      hok_r    <= 1'b1;
      int_r    <= '0;
      frac_r   <= '0;
      fcnt_r   <= '0;
      dot_r    <= 1'b0;
      flen_r   <= '0;
      status_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hc_r     <= hc_nxt;
      hok_r    <= hok_nxt;
      int_r    <= int_nxt;
      frac_r   <= frac_nxt;
      fcnt_r   <= fcnt_nxt;
      dot_r    <= dot_nxt;
      flen_r   <= flen_nxt;
      status_r <= status_nxt;
    end
  end

  // A field is handed on only when its hemisphere letter arrives.
  a_push_on_hemi: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (take && (is_ns || is_ew)))
    else $error("field handed on without a hemisphere letter");

endmodule

/* rtl/nrpe_job_queue.sv */
module nrpe_job_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nrpe_pkg::job_t din,
  input  logic           pop,
  output nrpe_pkg::job_t dout,
  output logic           full,
  output logic           empty
);
  import nrpe_pkg::*;

  job_t             mem_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [JQ_AW:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (JQ_AW+1)'(JQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_jq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (JQ_AW+1)'(JQ_DEPTH))
    else $error("job queue count beyond depth");

endmodule

/* rtl/nrpe_convert.sv */
module nrpe_convert (
  input  logic           clk,
  input  logic           rst_n,
  input  nrpe_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_pop,
  output nrpe_pkg::res_t res,
  output logic           res_push,
  input  logic           res_full
);
  import nrpe_pkg::*;

  logic adv;

  // Stage 1: integer part times the reciprocal of 100.
  logic              v1_r;
  tag_t              t1_r;
  logic [INT_W-1:0]  i1_r;
  logic [FRAC_W-1:0] f1_r;
  logic [FCNT_W-1:0] n1_r;
  logic [32:0]       p1_r;
  // Stage 2: quotient estimate and its multiple of 100.
  logic              v2_r;
  tag_t              t2_r;
  logic [INT_W-1:0]  i2_r;
  logic [FRAC_W-1:0] f2_r;
  logic [FCNT_W-1:0] n2_r;
  logic [10:0]       q2_r;
  logic [16:0]       qm2_r;
  // Stage 3: corrected degrees and whole minutes.
  logic              v3_r;
  tag_t              t3_r;
  logic [FRAC_W-1:0] f3_r;
  logic [FCNT_W-1:0] n3_r;
  logic [10:0]       deg3_r;
  logic [6:0]        mm3_r;
  // Stage 4: minutes * 10^n + fraction, degrees * 10^7.
  logic              v4_r;
  tag_t              t4_r;
  logic [FCNT_W-1:0] n4_r;
  logic [23:0]       a4_r;
  logic [33:0]       dg4_r;
  // Stage 5: minutes * 10^7 / 4.
  logic              v5_r;
  tag_t              t5_r;
  logic [33:0]       dg5_r;
  logic [27:0]       y5_r;
  // Stage 6: times the reciprocal of 15.
  logic              v6_r;
  tag_t              t6_r;
  logic [33:0]       dg6_r;
  logic [27:0]       y6_r;
  logic [55:0]       py6_r;
  // Stage 7: quotient estimate and its multiple of 15.
  logic              v7_r;
  tag_t              t7_r;
  logic [33:0]       dg7_r;
  logic [27:0]       y7_r;
  logic [23:0]       q7_r;
  logic [27:0]       qm7_r;
  // Stage 8: corrected minutes in 1e-7 degrees.
  logic              v8_r;
  tag_t              t8_r;
  logic [33:0]       dg8_r;
  logic [23:0]       num8_r;
  // Stage 9: saturated magnitude.
  logic              v9_r;
  tag_t              t9_r;
  logic [30:0]       mag9_r;

  logic [30:0]       lat_r;

  logic [16:0]       r3;
  logic [47:0]       x5;
  logic [27:0]       r8;
  logic [33:0]       sum9;
  logic [30:0]       lim9;
  logic [31:0]       val;
  tag_t              tag_in;

  assign adv     = !(v9_r && t9_r.is_lon && res_full);
  assign job_pop = adv && job_valid;

  assign tag_in.zero   = job.zero;
  assign tag_in.neg    = job.neg;
  assign tag_in.is_lon = job.is_lon;
  assign tag_in.status = job.status;

  assign r3   = i2_r - qm2_r;
  assign x5   = 48'(a4_r) * 48'(scale7(n4_r));
  assign r8   = y7_r - qm7_r;
  assign sum9 = dg8_r + 34'(num8_r);
  assign lim9 = t8_r.is_lon ? LON_LIMIT : LAT_LIMIT;
  assign val  = t9_r.neg ? (32'd0 - {1'b0, mag9_r}) : {1'b0, mag9_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r  <= tag_in;
      i1_r  <= job.int_acc;
      f1_r  <= job.frac_acc;
      n1_r  <= job.frac_cnt;
      p1_r  <= 33'(job.int_acc) * 33'(DIV100_K);

      t2_r  <= t1_r;
      i2_r  <= i1_r;
      f2_r  <= f1_r;
      n2_r  <= n1_r;
      q2_r  <= p1_r[32:22];
      qm2_r <= 17'(p1_r[32:22] * 17'd100);

      t3_r  <= t2_r;
      f3_r  <= f2_r;
      n3_r  <= n2_r;
      if (r3 >= 17'd100) begin
        deg3_r <= q2_r + 1'b1;
        mm3_r  <= 7'(r3 - 17'd100);
      end else begin
        deg3_r <= q2_r;
        mm3_r  <= r3[6:0];
      end

      t4_r  <= t3_r;
      n4_r  <= n3_r;
      a4_r  <= 24'(mm3_r) * 24'(pow10(n3_r)) + 24'(f3_r);
      dg4_r <= 34'(deg3_r) * 34'(E7);

      t5_r  <= t4_r;
      dg5_r <= dg4_r;
      y5_r  <= x5[29:2];

      t6_r  <= t5_r;
      dg6_r <= dg5_r;
      y6_r  <= y5_r;
      py6_r <= 56'(y5_r) * 56'(DIV15_K);

      t7_r  <= t6_r;
      dg7_r <= dg6_r;
      y7_r  <= y6_r;
      q7_r  <= py6_r[55:32];
      qm7_r <= 28'(py6_r[55:32]) * 28'd15;

      t8_r   <= t7_r;
      dg8_r  <= dg7_r;
      num8_r <= (r8 >= 28'd15) ? (q7_r + 1'b1) : q7_r;

      t9_r <= t8_r;
      if (t8_r.zero) begin
        mag9_r <= '0;
      end else if (sum9 > 34'(lim9)) begin
        mag9_r <= lim9;
      end else begin
        mag9_r <= sum9[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      lat_r <= '0;
    end else if (adv) begin
      v1_r <= job_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
      if (v9_r && !t9_r.is_lon) lat_r <= val[30:0];
    end
  end

  assign res_push          = adv && v9_r && t9_r.is_lon;
  assign res.latitude_e7   = lat_r;
  assign res.longitude_e7  = val;
  assign res.status_active = t9_r.status;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v9_r && !adv) |=> (v9_r && $stable(mag9_r) && $stable(t9_r)))
    else $error("stalled result changed");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

endmodule

/* rtl/nrpe_result_queue.sv */
module nrpe_result_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nrpe_pkg::res_t din,
  input  logic           pop,
  output nrpe_pkg::res_t dout,
  output logic           full,
  output logic           empty
);
  import nrpe_pkg::*;

  res_t             mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_AW:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (RQ_AW+1)'(RQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (RQ_AW+1)'(RQ_DEPTH))
    else $error("result queue count beyond depth");

endmodule

/* rtl/nmea_rmc_position_extractor.sv */
// Channel   | Ports                                            | Item taken when
// ----------+--------------------------------------------------+------------------
// input     | in_rx_byte, push, full                           | push && !full
// result    | out_latitude_e7, out_longitude_e7,               | pop && !empty
//           | out_status_active, empty, pop                    |
//
// One byte is taken every cycle while push is high and full is low; the parser
// state machine handles each byte in the cycle it arrives.
// After the edge that takes the longitude hemisphere letter, the field goes
// through the field queue and the nine-stage conversion pipeline, and the result
// then goes into the result queue; a full result queue stalls the pipeline.
// Reset (rst_n low at a clock edge) empties both queues and the pipeline and
// puts the parser back to waiting for a dollar sign.
// full rises only when the four-entry field queue fills, which happens only
// while results are left waiting on a full two-entry result queue.
module nmea_rmc_position_extractor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_rx_byte,
  input  logic               push,
  output logic               full,
  output logic signed [30:0] out_latitude_e7,
  output logic signed [31:0] out_longitude_e7,
  output logic               out_status_active,
  output logic               empty,
  input  logic               pop
);
  import nrpe_pkg::*;

  // The front end is the byte parser. Every time a coordinate field closes
  // on its hemisphere letter, it hands the raw accumulators (integer part,
  // kept fraction digits and their count) plus sign, kind and status to the
  // field queue. The back end turns each field into 1e-7 degrees:
  // degrees = I / 100, minutes = I % 100 + F / 10^n, and the value is
  // degrees * 10^7 + floor((mm * 10^n + F) * 10^(7-n) / 60). Both divisions
  // by constants use a reciprocal multiply with one correction step.
  // The latitude of a sentence is kept in the back end until its longitude
  // comes through, and then the pair goes into the result queue.

  logic  take;
  logic  job_push, jq_full, jq_empty, job_pop;
  job_t  job_in, job_out;
  logic  res_push, rq_full;
  res_t  res_in, res_out;

  assign full = jq_full;
  assign take = push && !jq_full;

  nrpe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .rx_byte  (in_rx_byte),
    .job_push (job_push),
    .job      (job_in)
  );

  nrpe_job_queue u_job_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_out),
    .full  (jq_full),
    .empty (jq_empty)
  );

  nrpe_convert u_convert (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .job_valid (!jq_empty),
    .job_pop   (job_pop),
    .res       (res_in),
    .res_push  (res_push),
    .res_full  (rq_full)
  );

  nrpe_result_queue u_result_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .pop   (pop),
    .dout  (res_out),
    .full  (rq_full),
    .empty (empty)
  );

  assign out_latitude_e7   = res_out.latitude_e7;
  assign out_longitude_e7  = res_out.longitude_e7;
  assign out_status_active = res_out.status_active;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

// Testbench for the RMC position extractor. Characters of NMEA text are pushed
// into the parser one item at a time. A tracker object follows the same
// sentence grammar as the block, works out the position fix that each
// sentence should give, and checks every popped result against the oldest fix
// still waiting. The stimulus opens with hand-written sentences for the
// corner cases. Random sentences follow: mostly well formed, and some broken,
// noisy or cut short.
module tb;
  import nrpe_pkg::*;

  // Parser phases as the tracker sees them.
  typedef enum logic [2:0] {
    WAIT_DOLLAR,
    IN_HEADER,
    SEEK_STATUS,
    LAT_DIGITS,
    LAT_LETTER,
    LON_DIGITS,
    LON_LETTER
  } rmc_phase_e;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam int IDLE_PCT       = 11;
  localparam int RX_HOLD_CYCLES = 1500;
  localparam int RANDOM_CHARS   = 575;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LIMIT_CYCLES   = 200000;

  // The tracker keeps its own copy of the parser state. note_char() feeds it
  // one accepted character, and check_fix() compares one popped result with
  // the oldest fix that is still owed.
  class rmc_fix_tracker;
    rmc_phase_e  phase;
    int unsigned hdr_count;
    bit          hdr_ok;
    int unsigned int_acc;
    int unsigned frac_acc;
    int unsigned frac_cnt;
    bit          dot_seen;
    int unsigned field_len;
    logic [30:0] saved_lat;
    bit          fix_active;
    string       rmc_tag;
    res_t        pending[$];
    int          fixes_expected;
    int          fixes_seen;
    int          errors;

    function new();
      rmc_tag        = "GPRMC";
      phase          = WAIT_DOLLAR;
      hdr_count      = 0;
      hdr_ok         = 1'b1;
      saved_lat      = '0;
      fix_active     = 1'b0;
      fixes_expected = 0;
      fixes_seen     = 0;
      errors         = 0;
      clear_field();
    endfunction

    function void clear_field();
      int_acc   = 0;
      frac_acc  = 0;
      frac_cnt  = 0;
      dot_seen  = 1'b0;
      field_len = 0;
    endfunction

    // One character of a coordinate field. Digits before the dot build the
    // integer part, which saturates. Only the first few digits after the dot
    // are kept. Anything else only makes the field longer.
    function void take_field_char(logic [7:0] c);
      int unsigned grown;
      if (field_len >= MAX_FIELD) begin
        clear_field();
        phase = WAIT_DOLLAR;
        return;
      end
      field_len++;
      if (c >= CH_0 && c <= CH_9) begin
        if (!dot_seen) begin
          grown   = int_acc * 10 + (c - CH_0);
          int_acc = (grown > INT_SAT) ? INT_SAT : grown;
        end else if (frac_cnt < FRAC_DIGITS) begin
          frac_acc = frac_acc * 10 + (c - CH_0);
          frac_cnt++;
        end
      end else if (c == CH_DOT) begin
        dot_seen = 1'b1;
      end
    endfunction

    // ddmm.mmmm to degrees in 1e-7 units: whole degrees, plus minutes over
    // sixty, truncated, clamped to the limit and then given its sign.
    function logic [31:0] to_e7(bit neg, longint unsigned limit);
      longint unsigned scale, deg, mins, part, val;
      if (field_len <= SHORT_FIELD) return '0;
      scale = 1;
      for (int k = 0; k < frac_cnt; k++) scale = scale * 10;
      deg  = int_acc / 100;
      mins = int_acc % 100;
      part = ((mins * scale + frac_acc) * E7) / (60 * scale);
      val  = deg * E7 + part;
      if (val > limit) val = limit;
      if (neg) val = 0 - val;
      return val[31:0];
    endfunction

    function void close_latitude(bit south);
      logic [31:0] lat_bits;
      lat_bits  = to_e7(south, LAT_LIMIT);
      saved_lat = lat_bits[30:0];
      clear_field();
      phase = LON_DIGITS;
    endfunction

    function void close_longitude(bit west);
      res_t fix;
      fix.latitude_e7   = saved_lat;
      fix.longitude_e7  = to_e7(west, LON_LIMIT);
      fix.status_active = fix_active;
      pending.push_back(fix);
      fixes_expected++;
      clear_field();
      phase = WAIT_DOLLAR;
    endfunction

    function void note_char(logic [7:0] c);
      if (c == CH_NUL) return;
      // A dollar sign restarts the header match wherever it shows up.
      if (c == CH_DOLLAR) begin
        phase     = IN_HEADER;
        hdr_count = 0;
        hdr_ok    = 1'b1;
        clear_field();
        return;
      end
      case (phase)
        IN_HEADER: begin
          if (c != rmc_tag[hdr_count]) hdr_ok = 1'b0;
          hdr_count++;
          if (hdr_count >= HEADER_LEN) begin
            phase     = hdr_ok ? SEEK_STATUS : WAIT_DOLLAR;
            hdr_count = 0;
          end
        end
        SEEK_STATUS: begin
          if (c == CH_A || c == CH_V) begin
            fix_active = (c == CH_A);
            clear_field();
            phase = LAT_DIGITS;
          end
        end
        LAT_DIGITS: begin
          if (c == CH_N || c == CH_S) close_latitude(c == CH_S);
          else if (c == CH_COMMA) begin
            if (field_len != 0) phase = LAT_LETTER;
          end else take_field_char(c);
        end
        LAT_LETTER: begin
          if (c == CH_N || c == CH_S) close_latitude(c == CH_S);
        end
        LON_DIGITS: begin
          if (c == CH_E || c == CH_W) close_longitude(c == CH_W);
          else if (c == CH_COMMA) begin
            if (field_len != 0) phase = LON_LETTER;
          end else take_field_char(c);
        end
        LON_LETTER: begin
          if (c == CH_E || c == CH_W) close_longitude(c == CH_W);
        end
        default: phase = WAIT_DOLLAR;
      endcase
    endfunction

    function void check_fix(logic [30:0] lat, logic [31:0] lon, logic active);
      res_t want;
      if (pending.size() == 0) begin
        $error("result with no fix pending: latitude_e7 %0d, longitude_e7 %0d",
               $signed(lat), $signed(lon));
        errors++;
        return;
      end
      want = pending.pop_front();
      fixes_seen++;
      if (lat !== want.latitude_e7) begin
        $error("latitude_e7: expected %0d, actual %0d", want.latitude_e7, $signed(lat));
        errors++;
      end
      if (lon !== want.longitude_e7) begin
        $error("longitude_e7: expected %0d, actual %0d", want.longitude_e7, $signed(lon));
        errors++;
      end
      if (active !== want.status_active) begin
        $error("status_active: expected %0b, actual %0b", want.status_active, active);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic [7:0]         in_rx_byte;
  logic               push;
  logic               full;
  logic signed [30:0] out_latitude_e7;
  logic signed [31:0] out_longitude_e7;
  logic               out_status_active;
  logic               empty;
  logic               pop;

  rmc_fix_tracker tracker;
  logic [7:0]     tx_bytes[$];
  int             chars_sent;
  int             cycle_count;
  bit             tx_steady;
  bit             hold_request;
  bit             hold_served;

  nmea_rmc_position_extractor uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_rx_byte       (in_rx_byte),
    .push             (push),
    .full             (full),
    .out_latitude_e7  (out_latitude_e7),
    .out_longitude_e7 (out_longitude_e7),
    .out_status_active(out_status_active),
    .empty            (empty),
    .pop              (pop)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run is cut short if something hangs, such as a result that never
  // shows up or an input that stays full for good.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Results are checked at the rising edge where they are popped.
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      tracker.check_fix(out_latitude_e7, out_longitude_e7, out_status_active);
  end

  // Result side. Pops are dropped at random, except in a stretch of results
  // where the consumer takes every one. The consumer also holds off once for a
  // long time, which fills the queues inside the block so that it stalls its
  // input.
  initial begin
    pop = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        pop = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      if (tracker.fixes_seen >= 15 && tracker.fixes_seen < 35)
        pop = 1'b1;
      else
        pop = ($urandom_range(0, 99) >= IDLE_PCT);
      @(negedge clk);
    end
  end

  // Offers one character and holds it until the block takes it. The task is
  // entered at a falling edge and returns at a falling edge. push is left high
  // so that back-to-back items need no gap.
  task automatic send_byte(input logic [7:0] ch);
    while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      push = 1'b0;
      @(negedge clk);
    end
    in_rx_byte = ch;
    push       = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_char(ch);
    if (ch != CH_NUL) chars_sent++;
    @(negedge clk);
  endtask

  // Sends everything queued up. Stray zero bytes can be mixed in, and the
  // block should skip them.
  task automatic send_queued(input bit sprinkle_nul);
    logic [7:0] ch;
    while (tx_bytes.size() != 0) begin
      ch = tx_bytes.pop_front();
      if (sprinkle_nul && $urandom_range(0, 49) == 0) send_byte(CH_NUL);
      send_byte(ch);
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endtask

  task automatic add_digits(input int count);
    repeat (count) tx_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  // One coordinate field. Most are well formed, with degrees and minutes now
  // and then past their limits and a varying number of fraction digits. The
  // rest are empty, short, too long, overflowing or plain garbage.
  task automatic add_coord(input bit is_lon);
    int shape;
    int deg;
    int mins;
    shape = $urandom_range(0, 19);
    case (shape)
      0: ;
      1: add_digits($urandom_range(1, 5));
      2: begin
        repeat ($urandom_range(26, 34))
          tx_bytes.push_back(($urandom_range(0, 9) == 0) ? CH_DOT
                                                         : CH_0 + 8'($urandom_range(0, 9)));
      end
      3: repeat ($urandom_range(6, 14)) tx_bytes.push_back(8'($urandom_range(1, 255)));
      4: add_digits($urandom_range(6, 12));
      default: begin
        if (is_lon) begin
          deg = ($urandom_range(0, 9) == 0) ? $urandom_range(180, 999) : $urandom_range(0, 179);
          add_text($sformatf("%03d", deg));
        end else begin
          deg = ($urandom_range(0, 9) == 0) ? $urandom_range(90, 99) : $urandom_range(0, 89);
          add_text($sformatf("%02d", deg));
        end
        mins = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
        add_text($sformatf("%02d", mins));
        if ($urandom_range(0, 7) != 0) begin
          tx_bytes.push_back(CH_DOT);
          add_digits($urandom_range(0, 7));
        end
      end
    endcase
  endtask

  // One random sentence. Noise can come before it, a restarted header can
  // come ahead of it, and the header, the hemisphere letters or the tail can
  // be broken or missing.
  task automatic add_random_sentence();
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 20)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 19) == 0) add_text("$GPRMC,A,12");
    if ($urandom_range(0, 9) == 0) begin
      add_text("$GP");
      tx_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
      add_text("MC");
    end else begin
      add_text("$GPRMC");
    end
    if ($urandom_range(0, 1) == 1) begin
      add_text(",");
      add_digits(6);
      add_text(".00");
    end
    add_text(",");
    tx_bytes.push_back($urandom_range(0, 1) ? CH_A : CH_V);
    add_text(",");
    add_coord(1'b0);
    add_text(",");
    if ($urandom_range(0, 9) == 0) add_text("junk,");
    if ($urandom_range(0, 24) != 0) tx_bytes.push_back($urandom_range(0, 1) ? CH_N : CH_S);
    add_text(",");
    add_coord(1'b1);
    add_text(",");
    if ($urandom_range(0, 24) != 0) tx_bytes.push_back($urandom_range(0, 1) ? CH_E : CH_W);
    if ($urandom_range(0, 3) == 0) add_text(",0.5,54.7,191194,020.3,E*68");
    tx_bytes.push_back(CH_CR);
    tx_bytes.push_back(CH_LF);
  endtask

  initial begin
    string directed[$];
    int    random_start;
    int    sentence_idx;

    tracker      = new();
    chars_sent   = 0;
    tx_steady    = 1'b0;
    hold_request = 1'b0;
    hold_served  = 1'b0;
    rst_n        = 1'b0;
    push         = 1'b0;
    in_rx_byte   = CH_NUL;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The consumer starts its long hold-off right away while the sender keeps
    // offering the directed sentences, so the block has to fill up and stall.
    hold_request = 1'b1;

    // Directed sentences: a textbook fix, south and west, both ends of the
    // range, saturation, integer overflow, short fields, leading commas, a
    // comma inside a field, hemisphere letters inside the number, extra
    // fraction digits, dollar restarts, a wrong header, over-long and
    // just-fitting fields, stray characters and a negative zero.
    directed = '{
      "$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A",
      "$GPRMC,V,3351.1234,S,15112.5678,W",
      "$GPRMC,A,9000.00000,N,18000.00000,W",
      "$GPRMC,A,9959.99999,S,99999.99999,E",
      "$GPRMC,A,99999999.9,N,123456789012,E",
      "$GPRMC,A,12345,N,1.2,W",
      "$GPRMC,A,123456,S,0000.0,E",
      "$GPRMC,V,,,4807.038,N,,01131.000,E",
      "$GPRMC,A,4807.038,junk,N,01131.000,9.9,E",
      "$GPRMC,A,4807N01131.5E",
      "$GPRMC,A,4807.0381234,N,01131.00099999,E",
      "$GPR$GPRMC,A,4807.038,N,01131$GPRMC,V,0000.0001,S,00000.00001,W",
      "$GPGGA,A,4807.038,N,01131.000,E",
      "$GPRMC,A,1234567890123456789012345678901,N,00100.0,E",
      "$GPRMC,A,123456789012345678901234567890,N,00100.0,E",
      "$GPRMC,A,48x07.0.3-8,N,011+31.000,E",
      "$GPRMC,A,0000.00000,S,00000.00000,W",
      "$GPRMC,A,8959.99999,N,17959.99999,E"
    };
    foreach (directed[i]) begin
      add_text(directed[i]);
      send_queued(1'b0);
    end

    // Zero bytes and bytes with the top bit set, some of them inside a field.
    add_text("$GP");
    tx_bytes.push_back(CH_NUL);
    add_text("RMC,A,48");
    tx_bytes.push_back(8'hFF);
    add_text("07.5");
    tx_bytes.push_back(8'h80);
    add_text(",N,0113");
    tx_bytes.push_back(CH_NUL);
    add_text("1.0,E");
    tx_bytes.push_back(8'h7F);
    send_queued(1'b0);

    // The sender goes quiet until every fix owed so far has been popped.
    push = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk);

    // Random part, with a run of sentences sent without any idle cycles.
    random_start = chars_sent;
    sentence_idx = 0;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      tx_steady = (sentence_idx >= 3 && sentence_idx < 9);
      add_random_sentence();
      send_queued(1'b1);
      sentence_idx++;
    end
    tx_steady = 1'b0;
    push      = 1'b0;

    // Wait until every fix has been popped, then a while longer so that any
    // extra result would still be caught.
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/nrpe_pkg.sv
rtl/nrpe_front.sv
rtl/nrpe_job_queue.sv
rtl/nrpe_convert.sv
rtl/nrpe_result_queue.sv
rtl/nmea_rmc_position_extractor.sv
verif/tb.sv
